// ===== rtl/bbr_pkg.sv =====
package bbr_pkg;

    localparam int MaxWidth   = 2048;
    localparam int MaxHeight  = 4096;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int RowW       = $clog2(MaxHeight) + 1;
    localparam int WidthW     = 12;
    localparam int HeightW    = 13;
    localparam int CfgIdxW    = 8;
    localparam int CfgDataW   = 13;
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = QPtrW + 1;
    localparam int RecipShift = 18;

    localparam logic [CfgIdxW-1:0] CfgWidth  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgHeight = CfgIdxW'(1);

    localparam logic [WidthW-1:0]  WidthReset  = WidthW'(640);
    localparam logic [HeightW-1:0] HeightReset = HeightW'(480);

    // one window column plus what the back end must know about it
    typedef struct packed {
        logic [23:0] up;
        logic [23:0] mid;
        logic [23:0] low;
        logic        emit;
        logic        top;
        logic        bot;
        logic        left;
        logic        right;
        logic        fend;
    } t_col_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fend;
    } t_pix_out;

    // ceil(2^18 / (2*count)) for the counts a clipped 3x3 window can have
    function automatic logic [17:0] recip(input logic [3:0] cnt);
        logic [17:0] r;
        case (cnt)
            4'd1:    r = 18'd131072;
            4'd2:    r = 18'd65536;
            4'd3:    r = 18'd43691;
            4'd4:    r = 18'd32768;
            4'd6:    r = 18'd21846;
            4'd9:    r = 18'd14564;
            default: r = 18'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/box_blur_3x3_rgb_core.sv =====
// 3x3 box blur over an rgb pixel stream in raster order. Each result is the
// mean of the in-frame neighbors of one pixel, rounded half up; it appears one
// row plus one item after that pixel is pushed, so after the last pixel of a
// frame push image_width + 1 items with drain set; frame_end marks the last
// result. The block takes one item per clock when not full: the line stores
// are read at the edge that takes an item and written in the next cycle, and
// the back end (sum, then reciprocal multiply) keeps pace. Writing either size
// register restarts the frame; write registers only while the block is idle.
module box_blur_3x3_rgb_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   i_red_in,
    input  logic [7:0]                   i_green_in,
    input  logic [7:0]                   i_blue_in,
    input  logic                         i_drain,
    output logic                         empty,
    input  logic                         pop,
    output logic [7:0]                   o_red_out,
    output logic [7:0]                   o_green_out,
    output logic [7:0]                   o_blue_out,
    output logic                         o_frame_end,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bbr_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [bbr_pkg::CfgDataW-1:0] i_cfg_data
);
    import bbr_pkg::*;

    logic             q_push, q_pop;
    t_col_item        q_in, q_out;
    logic [QCntW-1:0] q_count;
    t_pix_out         pix;

    assign o_cfg_ready = 1'b1;

    // front end: position tracking and line stores
    bbr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_red       (i_red_in),
        .i_green     (i_green_in),
        .i_blue      (i_blue_in),
        .i_drain     (i_drain),
        .o_full      (full),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_count   (q_count),
        .o_q_push    (q_push),
        .o_q_item    (q_in)
    );

    // column queue between the two halves
    bbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_count (q_count)
    );

    // back end: window, averaging and result queue
    bbr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_item  (q_out),
        .i_q_count (q_count),
        .o_q_pop   (q_pop),
        .o_pix     (pix),
        .o_empty   (empty),
        .i_pop     (pop)
    );

    assign o_red_out   = pix.red;
    assign o_green_out = pix.green;
    assign o_blue_out  = pix.blue;
    assign o_frame_end = pix.fend;
endmodule

// ===== rtl/bbr_queue.sv =====
module bbr_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  bbr_pkg::t_col_item      i_item,
    input  logic                    i_pop,
    output bbr_pkg::t_col_item      o_item,
    output logic [bbr_pkg::QCntW-1:0] o_count
);
    import bbr_pkg::*;

    t_col_item              r_mem [QueueDepth];
    logic [QPtrW-1:0]       r_wr, r_rd;
    logic [QCntW-1:0]       r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPtrW'(1);
            if (i_pop)  r_rd <= r_rd + QPtrW'(1);
            r_count <= r_count + QCntW'(i_push) - QCntW'(i_pop);
        end
    end

    assign o_item  = r_mem[r_rd];
    assign o_count = r_count;
endmodule

// ===== rtl/bbr_front.sv =====
module bbr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [7:0]                  i_red,
    input  logic [7:0]                  i_green,
    input  logic [7:0]                  i_blue,
    input  logic                        i_drain,
    output logic                        o_full,
    input  logic                        i_cfg_we,
    input  logic [bbr_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [bbr_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic [bbr_pkg::QCntW-1:0]   i_q_count,
    output logic                        o_q_push,
    output bbr_pkg::t_col_item          o_q_item
);
    import bbr_pkg::*;

    logic [WidthW-1:0]  r_width;
    logic [HeightW-1:0] r_height;
    logic [RowW-1:0]    r_row, r_orow;
    logic [ColW-1:0]    r_col, r_ocol;

    logic [23:0] r_upper [MaxWidth];
    logic [23:0] r_lower [MaxWidth];

    logic        r_s1_valid;
    logic [ColW-1:0] r_s1_col;
    logic [23:0] r_s1_pix;
    logic [23:0] r_rd_u, r_rd_l;
    logic        r_s1_emit, r_s1_top, r_s1_bot, r_s1_left, r_s1_right, r_s1_fend;

    logic        r_fwd_valid;
    logic [ColW-1:0] r_fwd_col;
    logic [23:0] r_fwd_l, r_fwd_p;

    logic        accept, in_frame, advance, emit, fend;
    logic [ColW-1:0] w_last;
    logic [RowW-1:0] h_last;
    logic [23:0] pix, eff_u, eff_l;
    logic [WidthW-1:0]  n_width;
    logic [HeightW-1:0] n_height;

    // keep one queue slot for the item in flight
    assign o_full = (QCntW'(r_s1_valid) + i_q_count) >= QCntW'(QueueDepth);
    assign accept = i_push && !o_full;

    // classify the item against the frame position
    assign w_last   = ColW'(r_width - WidthW'(1));
    assign h_last   = RowW'(r_height - HeightW'(1));
    assign in_frame = r_row < RowW'(r_height);
    assign advance  = accept && (!in_frame || !i_drain);
    assign pix      = in_frame ? {i_red, i_green, i_blue} : 24'd0;
    assign emit     = (r_row >= RowW'(2)) || (r_row == RowW'(1) && r_col != '0);
    assign fend     = emit && r_orow == h_last && r_ocol == w_last;

    // saturated frame sizes
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we && i_cfg_index == CfgWidth) begin
            if (i_cfg_data[WidthW-1:0] == '0) begin
                n_width = WidthW'(1);
            end else if (i_cfg_data[WidthW-1:0] > WidthW'(MaxWidth)) begin
                n_width = WidthW'(MaxWidth);
            end else begin
                n_width = i_cfg_data[WidthW-1:0];
            end
        end
        if (i_cfg_we && i_cfg_index == CfgHeight) begin
            if (i_cfg_data == '0) begin
                n_height = HeightW'(1);
            end else if (i_cfg_data > HeightW'(MaxHeight)) begin
                n_height = HeightW'(MaxHeight);
            end else begin
                n_height = i_cfg_data;
            end
        end
    end

    // frame position and output position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WidthReset;
            r_height <= HeightReset;
            r_row    <= '0;
            r_col    <= '0;
            r_orow   <= '0;
            r_ocol   <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            if (i_cfg_we && (i_cfg_index == CfgWidth || i_cfg_index == CfgHeight)) begin
                r_row  <= '0;
                r_col  <= '0;
                r_orow <= '0;
                r_ocol <= '0;
            end else if (advance) begin
                if (fend) begin
                    r_row  <= '0;
                    r_col  <= '0;
                    r_orow <= '0;
                    r_ocol <= '0;
                end else begin
                    if (r_col == w_last) begin
                        r_col <= '0;
                        r_row <= r_row + RowW'(1);
                    end else begin
                        r_col <= r_col + ColW'(1);
                    end
                    if (emit) begin
                        if (r_ocol == w_last) begin
                            r_ocol <= '0;
                            r_orow <= r_orow + RowW'(1);
                        end else begin
                            r_ocol <= r_ocol + ColW'(1);
                        end
                    end
                end
            end
        end
    end

    // stage valid and bypass control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1_valid  <= advance;
            r_fwd_valid <= r_s1_valid;
        end
    end

    // line store read and stage payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rd_u     <= r_upper[r_col];
            r_rd_l     <= r_lower[r_col];
            r_s1_col   <= r_col;
            r_s1_pix   <= pix;
            r_s1_emit  <= emit;
            r_s1_top   <= r_orow == '0;
            r_s1_bot   <= r_orow >= h_last;
            r_s1_left  <= r_ocol == '0;
            r_s1_right <= r_ocol == w_last;
            r_s1_fend  <= fend;
        end
        if (r_s1_valid) begin
            r_upper[r_s1_col] <= eff_l;
            r_lower[r_s1_col] <= r_s1_pix;
        end
        r_fwd_col <= r_s1_col;
        r_fwd_l   <= eff_l;
        r_fwd_p   <= r_s1_pix;
    end

    // the previous item may write the same column too late for this item's read
    always_comb begin
        eff_u = r_rd_u;
        eff_l = r_rd_l;
        if (r_fwd_valid && r_fwd_col == r_s1_col) begin
            eff_u = r_fwd_l;
            eff_l = r_fwd_p;
        end
    end

    assign o_q_push       = r_s1_valid;
    assign o_q_item.up    = eff_u;
    assign o_q_item.mid   = eff_l;
    assign o_q_item.low   = r_s1_pix;
    assign o_q_item.emit  = r_s1_emit;
    assign o_q_item.top   = r_s1_top;
    assign o_q_item.bot   = r_s1_bot;
    assign o_q_item.left  = r_s1_left;
    assign o_q_item.right = r_s1_right;
    assign o_q_item.fend  = r_s1_fend;
endmodule

// ===== rtl/bbr_back.sv =====
module bbr_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bbr_pkg::t_col_item        i_q_item,
    input  logic [bbr_pkg::QCntW-1:0] i_q_count,
    output logic                      o_q_pop,
    output bbr_pkg::t_pix_out         o_pix,
    output logic                      o_empty,
    input  logic                      i_pop
);
    import bbr_pkg::*;

    logic [23:0] r_win [3][3];
    logic        r_a_valid, r_b_valid;
    logic        r_a_top, r_a_bot, r_a_left, r_a_right, r_a_fend;
    logic [12:0] r_b_num [3];
    logic [17:0] r_b_rcp;
    logic        r_b_fend;

    t_pix_out           r_oq [QueueDepth];
    logic [QPtrW-1:0]   r_owr, r_ord;
    logic [QCntW-1:0]   r_ocount;

    logic        out_pop;
    logic [11:0] sum [3];
    logic [3:0]  cnt;
    logic [30:0] prod [3];
    t_pix_out    res;

    // pop only when every item in flight has an output slot
    assign o_q_pop = (i_q_count != '0) &&
        ((r_ocount + QCntW'(r_a_valid) + QCntW'(r_b_valid)) < QCntW'(QueueDepth));
    assign out_pop = i_pop && !o_empty;

    // window shift on every column
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_q_item.up;
            r_win[1][2] <= i_q_item.mid;
            r_win[2][2] <= i_q_item.low;
            r_a_top   <= i_q_item.top;
            r_a_bot   <= i_q_item.bot;
            r_a_left  <= i_q_item.left;
            r_a_right <= i_q_item.right;
            r_a_fend  <= i_q_item.fend;
        end
    end

    // masked channel sums and pixel count
    always_comb begin
        cnt = '0;
        for (int c = 0; c < 3; c++) sum[c] = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (!(i == 0 && r_a_top) && !(i == 2 && r_a_bot) &&
                    !(j == 0 && r_a_left) && !(j == 2 && r_a_right)) begin
                    cnt = cnt + 4'd1;
                    for (int c = 0; c < 3; c++) begin
                        sum[c] = sum[c] + 12'(r_win[i][j][8*(2-c) +: 8]);
                    end
                end
            end
        end
    end

    // rounded numerator, then reciprocal multiply
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_b_num[c] <= {sum[c], 1'b0} + 13'(cnt);
        end
        r_b_rcp  <= recip(cnt);
        r_b_fend <= r_a_fend;
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = 31'(r_b_num[c]) * 31'(r_b_rcp);
        end
        res.red   = prod[0][RecipShift +: 8];
        res.green = prod[1][RecipShift +: 8];
        res.blue  = prod[2][RecipShift +: 8];
        res.fend  = r_b_fend;
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= o_q_pop && i_q_item.emit;
            r_b_valid <= r_a_valid;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_oq[r_owr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr    <= '0;
            r_ord    <= '0;
            r_ocount <= '0;
        end else begin
            if (r_b_valid) r_owr <= r_owr + QPtrW'(1);
            if (out_pop)   r_ord <= r_ord + QPtrW'(1);
            r_ocount <= r_ocount + QCntW'(r_b_valid) - QCntW'(out_pop);
        end
    end

    assign o_empty = r_ocount == '0;
    assign o_pix   = r_oq[r_ord];
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bbr_pkg::*;

    // one blurred pixel as it leaves the block
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fend;
    } blur_px_t;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [7:0]          red_in;
    logic [7:0]          green_in;
    logic [7:0]          blue_in;
    logic                drain_in;
    logic                empty;
    logic                pop;
    logic [7:0]          red_out;
    logic [7:0]          green_out;
    logic [7:0]          blue_out;
    logic                frame_end;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    box_blur_3x3_rgb_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_red_in    (red_in),
        .i_green_in  (green_in),
        .i_blue_in   (blue_in),
        .i_drain     (drain_in),
        .empty       (empty),
        .pop         (pop),
        .o_red_out   (red_out),
        .o_green_out (green_out),
        .o_blue_out  (blue_out),
        .o_frame_end (frame_end),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // blur predictor state
    logic [23:0] upper_row [MaxWidth];
    logic [23:0] lower_row [MaxWidth];
    logic [23:0] win [3][3];
    int          row_pos;
    int          col_pos;
    int          width_reg;
    int          height_reg;

    blur_px_t    pending_px[$];
    int          errors;
    int          items_sent;
    int          px_checked;
    int          frames_ended;
    int          push_gap_max;
    int          pop_gap_max;
    int          pop_wait;
    int          quiet_cycles;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int clamp_width();
        if (width_reg < 1) return 1;
        if (width_reg > MaxWidth) return MaxWidth;
        return width_reg;
    endfunction

    function automatic int clamp_height();
        if (height_reg < 1) return 1;
        if (height_reg > MaxHeight) return MaxHeight;
        return height_reg;
    endfunction

    // advance the predicted window by one item, returns 1 when a pixel comes out
    function automatic bit blur_advance(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic dr,
                                        output blur_px_t px);
        int w, h, total, k, col, o, ro, co, sr, sg, sb, cnt;
        logic [23:0] pix;
        logic [23:0] p;
        w = clamp_width();
        h = clamp_height();
        total = w * h;
        k = row_pos * w + col_pos;
        col = col_pos;
        pix = '0;
        if (k < total) begin
            if (dr) return 0;
            pix = {r, g, b};
        end
        if (col >= MaxWidth) col = MaxWidth - 1;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_row[col];
        win[1][2] = lower_row[col];
        win[2][2] = pix;
        upper_row[col] = lower_row[col];
        lower_row[col] = pix;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (k < w + 1) return 0;
        o = k - w - 1;
        ro = o / w;
        co = o % w;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (!((i == 0 && ro == 0) || (i == 2 && ro + 1 >= h) ||
                      (j == 0 && co == 0) || (j == 2 && co + 1 >= w))) begin
                    p = win[i][j];
                    sr += p[23:16];
                    sg += p[15:8];
                    sb += p[7:0];
                    cnt++;
                end
            end
        end
        px.red   = 8'((2 * sr + cnt) / (2 * cnt));
        px.green = 8'((2 * sg + cnt) / (2 * cnt));
        px.blue  = 8'((2 * sb + cnt) / (2 * cnt));
        px.fend  = 1'b0;
        if (o == total - 1) begin
            px.fend = 1'b1;
            row_pos = 0;
            col_pos = 0;
        end
        return 1;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on pixel %0d: %s got %0d expected %0d", px_checked, what, got, want);
        errors++;
    endtask

    // send one item, waiting a random gap first
    task automatic send_item(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic dr);
        int gap;
        blur_px_t px;
        gap = $urandom_range(0, push_gap_max);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        drain_in <= dr;
        do @(posedge clk); while (full);
        items_sent++;
        if (blur_advance(r, g, b, dr, px)) pending_px.push_back(px);
    endtask

    task automatic send_pixel();
        send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    endtask

    task automatic send_drains(input int n);
        repeat (n) send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    endtask

    // wait until every predicted pixel has come out, then let the pipe settle
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CfgDataW'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CfgWidth) begin
            width_reg = value & 12'hFFF;
        end else if (idx == CfgHeight) begin
            height_reg = value & 13'h1FFF;
        end
        if (idx == CfgWidth || idx == CfgHeight) begin
            row_pos = 0;
            col_pos = 0;
        end
    endtask

    task automatic set_size(input int w, input int h);
        write_reg(CfgWidth, w);
        write_reg(CfgHeight, h);
    endtask

    task automatic run_frame(input int w, input int h);
        set_size(w, h);
        repeat (clamp_width() * clamp_height()) send_pixel();
        send_drains(clamp_width() + 1);
        wait_idle();
    endtask

    // wide frame, two rows, items back to back
    task automatic test_wide_frame();
        push_gap_max = 0;
        pop_gap_max = 2;
        run_frame(160, 2);
    endtask

    // small directed frames covering value extremes and odd cases
    task automatic test_directed();
        push_gap_max = 3;
        pop_gap_max = 3;
        // all-max 3x3 frame, then all-zero
        set_size(3, 3);
        repeat (9) send_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_drains(4);
        wait_idle();
        set_size(3, 2);
        repeat (6) send_item(8'h00, 8'h00, 8'h00, 1'b0);
        send_drains(4);
        wait_idle();
        // drain inside the frame is ignored, pixel after frame acts as drain
        set_size(2, 2);
        send_pixel();
        send_drains(2);
        repeat (3) send_pixel();
        send_item(8'hAA, 8'h55, 8'hF0, 1'b0);
        send_item(8'h0F, 8'hC3, 8'h3C, 1'b0);
        send_drains(1);
        wait_idle();
        // zero sizes count as one, out-of-range index does nothing
        set_size(0, 0);
        write_reg(CfgIdxW'(5), 7);
        write_reg(CfgIdxW'(255), 8191);
        send_item(8'h80, 8'h7F, 8'h01, 1'b0);
        send_drains(2);
        wait_idle();
    endtask

    // tall frame of one column
    task automatic test_tall_frame();
        push_gap_max = 1;
        pop_gap_max = 1;
        run_frame(1, 300);
    endtask

    task automatic test_random_frames(input int target);
        int w, h, n, stop_at;
        while (items_sent < target) begin
            case ($urandom_range(0, 3))
                0: push_gap_max = 0;
                1: push_gap_max = 3;
                default: push_gap_max = 12;
            endcase
            pop_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0) write_reg(CfgIdxW'($urandom_range(2, 255)), h);
            set_size(w, h);
            n = w * h;
            stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
            for (int i = 0; i < stop_at; i++) begin
                if ($urandom_range(0, 19) == 0) send_drains(1);
                send_pixel();
            end
            if (stop_at == n) begin
                for (int i = 0; i <= w; i++) begin
                    if ($urandom_range(0, 3) == 0) send_pixel();
                    else send_drains(1);
                end
                if ($urandom_range(0, 4) == 0) send_drains($urandom_range(1, 3));
            end
            wait_idle();
        end
    endtask

    // result side: random pop stalls and checking against the oldest prediction
    always @(posedge clk) begin
        blur_px_t want;
        if (!rst_n) begin
            pop <= 1'b0;
            pop_wait = 0;
        end else begin
            if (pop && !empty) begin
                if (pending_px.size() == 0) begin
                    report("unexpected pixel", 1, 0);
                end else begin
                    want = pending_px.pop_front();
                    if (red_out !== want.red) report("red", red_out, want.red);
                    if (green_out !== want.green) report("green", green_out, want.green);
                    if (blue_out !== want.blue) report("blue", blue_out, want.blue);
                    if (frame_end !== want.fend) report("frame_end", frame_end, want.fend);
                    if (want.fend) frames_ended++;
                end
                px_checked++;
                pop_wait = $urandom_range(0, pop_gap_max);
            end
            if (pop_wait > 0) begin
                pop <= 1'b0;
                pop_wait--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 10000) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        push = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        drain_in = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        px_checked = 0;
        frames_ended = 0;
        quiet_cycles = 0;
        push_gap_max = 0;
        pop_gap_max = 0;
        width_reg = 640;
        height_reg = 480;
        row_pos = 0;
        col_pos = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        for (int i = 0; i < MaxWidth; i++) begin
            upper_row[i] = '0;
            lower_row[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_wide_frame();
        test_directed();
        test_tall_frame();
        test_random_frames(1400);
        wait_idle();

        $display("covered %0d items and %0d blurred pixels over %0d frames", items_sent,
                 px_checked, frames_ended);
        $display("sizes from 1x1 up to 160 wide and 300 tall, with idle gaps on both sides");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bbr_pkg.sv
rtl/bbr_queue.sv
rtl/bbr_front.sv
rtl/bbr_back.sv
rtl/box_blur_3x3_rgb_core.sv
tb/testbench.sv
